### rtl/pftc_pkg.sv
// ----------------------------------------------------------------------------
// pftc_pkg: shared definitions for the page frame buffer text console
// Opcodes, register word addresses, sequencer states and the glyph table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pftc_pkg;

	// Opcode field values.
	localparam logic [2:0] OP_FILL      = 3'd0;
	localparam logic [2:0] OP_SET_PIX   = 3'd1;
	localparam logic [2:0] OP_CLR_PIX   = 3'd2;
	localparam logic [2:0] OP_PUT_CUR   = 3'd3;
	localparam logic [2:0] OP_PUT_CELL  = 3'd4;
	localparam logic [2:0] OP_READ      = 3'd5;

	// Register word index, taken from paddr bit 2.
	localparam logic REG_X_ORIGIN = 1'b0;
	localparam logic REG_Y_ORIGIN = 1'b1;

	localparam logic [6:0] CHAR_NEWLINE = 7'd10;

	// Glyphs are six columns wide; column counters are three bits.
	localparam int GLYPH_WIDTH = 6;
	localparam logic [2:0] GLYPH_LAST = 3'(GLYPH_WIDTH - 1);

	// Text rows are limited to eight by the three-bit row field.
	localparam int MAX_TEXT_ROWS = 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_MODIFY,
		ST_GLYPH,
		ST_FINISH
	} pftc_state_t;

	typedef struct packed {
		logic mem_we;
		logic mem_re;
		logic advance;
		logic load_out;
	} pftc_ctrl_t;

	// One glyph as six column bytes, leftmost column in the top byte.
	function automatic logic [47:0] glyph_row(input logic [6:0] code);
		logic [47:0] row;
		case (code)
			7'h21: row = 48'h00FA00000000;
			7'h2C: row = 48'h000102000000;
			7'h2D: row = 48'h001010100000;
			7'h2E: row = 48'h000002000000;
			7'h30: row = 48'h7C8A92A27C00;
			7'h31: row = 48'h0242FE020200;
			7'h32: row = 48'h468A92926600;
			7'h33: row = 48'h448292926C00;
			7'h34: row = 48'h18284888FE00;
			7'h35: row = 48'hE4A2A2A29C00;
			7'h36: row = 48'h3C5292920C00;
			7'h37: row = 48'hC0808E90E000;
			7'h38: row = 48'h6C9292926C00;
			7'h39: row = 48'h609292947800;
			7'h3A: row = 48'h002400000000;
			7'h3B: row = 48'h022400000000;
			7'h3C: row = 48'h102844820000;
			7'h3D: row = 48'h242424240000;
			7'h3E: row = 48'h824428100000;
			7'h3F: row = 48'h40808A906000;
			7'h40: row = 48'h3C425A4A3A00;
			7'h41: row = 48'h7E9090907E00;
			7'h42: row = 48'hFE9292926C00;
			7'h43: row = 48'h7C8282824400;
			7'h44: row = 48'hFE8282827C00;
			7'h45: row = 48'hFE9292928200;
			7'h46: row = 48'hFE9090908000;
			7'h47: row = 48'h7C8282A2BC00;
			7'h48: row = 48'hFE101010FE00;
			7'h49: row = 48'h0082FE820000;
			7'h4A: row = 48'h04020202FC00;
			7'h4B: row = 48'hFE2020508E00;
			7'h4C: row = 48'hFE0202020000;
			7'h4D: row = 48'hFE402040FE00;
			7'h4E: row = 48'hFE402010FE00;
			7'h4F: row = 48'h7C8282827C00;
			7'h50: row = 48'hFE9090906000;
			7'h51: row = 48'h7C8282847A00;
			7'h52: row = 48'hFE9090906E00;
			7'h53: row = 48'h649292924C00;
			7'h54: row = 48'h8080FE808000;
			7'h55: row = 48'hFC020202FC00;
			7'h56: row = 48'hF00C020CF000;
			7'h57: row = 48'hFE040804FE00;
			7'h58: row = 48'hC6281028C600;
			7'h59: row = 48'h80403E408000;
			7'h5A: row = 48'h868A92A2C200;
			7'h5B: row = 48'h00FE82820000;
			7'h5C: row = 48'h8060100C0200;
			7'h5D: row = 48'h008282FE0000;
			7'h5E: row = 48'h204080402000;
			7'h5F: row = 48'h010101010100;
			default: row = 48'h0;
		endcase
		return row;
	endfunction

	function automatic logic [7:0] glyph_byte(input logic [6:0] code, input logic [2:0] idx);
		logic [47:0] row;
		logic [7:0]  col;
		row = glyph_row(code);
		case (idx)
			3'd0: col = row[47:40];
			3'd1: col = row[39:32];
			3'd2: col = row[31:24];
			3'd3: col = row[23:16];
			3'd4: col = row[15:8];
			3'd5: col = row[7:0];
			default: col = 8'h00;
		endcase
		return col;
	endfunction

endpackage

`default_nettype wire

### rtl/page_framebuffer_text_console.sv
// ----------------------------------------------------------------------------
// page_framebuffer_text_console: monochrome page frame store with text console
// A byte-wide frame store organised as pages of column bytes, with pixel set
// and clear, fill, byte read-back and glyph printing at a cursor or a cell.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Carries
//   -------   ---------   --------------------   --------------------------------
//   in        to block    in_valid / in_stall    opcode, pixel, char, cell, fill,
//                                                read address
//   out       from block  out_valid / out_stall  read_data, status, cursor
//   apb       to block    psel/penable/pready    x and y origin shift registers
//
// A word is taken in only while the sequencer is idle; it then owns the
// single-port frame store until its result sits in the output register.
// Newline, off-screen pixels and cells, out-of-range reads and unused opcodes
// go straight to the result stage; a read takes one store read, a pixel set
// or clear a read, modify and write-back on the one store port, a character
// six glyph columns (one store write each while on screen), and a fill one
// store write per byte. After reset the block sweeps zeros through the store
// and holds in_stall high meanwhile; register writes are taken as ever.
// A stalled output only holds the finished word; a new word is accepted and
// worked on meanwhile, and waits before its result stage until the output
// register is free.
//
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_text_console #(
	parameter int STORE_BYTES    = 1024,
	parameter int SCREEN_COLUMNS = 128,
	parameter int TEXT_COLUMNS   = 21
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        opcode,
	input  wire logic signed [8:0] pixel_x,
	input  wire logic signed [7:0] pixel_y,
	input  wire logic [6:0]        char_code,
	input  wire logic [4:0]        cell_col,
	input  wire logic [2:0]        cell_row,
	input  wire logic [7:0]        fill_value,
	input  wire logic [9:0]        read_addr,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             read_data,
	output logic                   status,
	output logic [4:0]             cursor_col_now,
	output logic [2:0]             cursor_row_now,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int PAGE_COUNT  = STORE_BYTES / SCREEN_COLUMNS;
	localparam int TEXT_ROWS   = (PAGE_COUNT < pftc_pkg::MAX_TEXT_ROWS) ?
	                             PAGE_COUNT : pftc_pkg::MAX_TEXT_ROWS;
	localparam int SCREEN_ROWS = PAGE_COUNT * 8;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_BYTES - 1);

	// Sequencer and control state.
	pftc_pkg::pftc_state_t state_q, state_next;
	pftc_pkg::pftc_ctrl_t  ctrl;

	logic [AW-1:0]     addr_q;
	logic [2:0]        step_q;
	logic [7:0]        glyph_x_q;
	logic [4:0]        cursor_col_q;
	logic [2:0]        cursor_row_q;
	logic signed [7:0] x_shift_q;
	logic signed [6:0] y_shift_q;
	logic              out_valid_q;

	// Per-word operands, loaded at acceptance.
	logic [2:0] op_q;
	logic [7:0] fill_q;
	logic [7:0] bit_q;
	logic [6:0] code_q;
	logic       status_q;
	logic       rd_sel_q;

	// Output register payload.
	logic [7:0] read_data_q;
	logic       status_out_q;
	logic [4:0] cursor_col_out_q;
	logic [2:0] cursor_row_out_q;

	// Frame store and its registered read port.
	logic [7:0] frame_store_q [STORE_BYTES];
	logic [7:0] mem_rdata_q;
	logic [7:0] mem_wdata;

	logic accept;
	logic out_free;

	// Pixel coordinate arithmetic.
	logic signed [9:0] x_sum;
	logic signed [8:0] y_sum;
	logic              pix_on_screen;
	logic [AW-1:0]     pix_addr;

	// Glyph placement.
	logic [4:0]    sel_col;
	logic [2:0]    sel_row;
	logic [AW-1:0] glyph_base;
	logic [7:0]    glyph_x0;
	logic          cell_on_screen;
	logic          rd_in_range;

	// Cursor after a printed character or a newline.
	logic [4:0] cur_col_next;
	logic [2:0] cur_row_next;
	logic [4:0] col_inc;
	logic [3:0] row_inc;

	assign accept   = in_valid && (state_q == pftc_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		x_sum = {pixel_x[8], pixel_x} + {{2{x_shift_q[7]}}, x_shift_q};
		y_sum = {pixel_y[7], pixel_y} + {{2{y_shift_q[6]}}, y_shift_q};
		pix_on_screen = !x_sum[9] && (x_sum[8:0] < 9'(SCREEN_COLUMNS)) &&
		                !y_sum[8] && (y_sum[7:0] < 8'(SCREEN_ROWS));
		// Page is y / 8, bit is y mod 8.
		pix_addr = AW'(int'(y_sum[7:3]) * SCREEN_COLUMNS + int'(x_sum[6:0]));
	end

	always_comb begin
		if (opcode == pftc_pkg::OP_PUT_CUR) begin
			sel_col = cursor_col_q;
			sel_row = cursor_row_q;
		end else begin
			sel_col = cell_col;
			sel_row = cell_row;
		end
		cell_on_screen = (int'(cell_col) < TEXT_COLUMNS) && (int'(cell_row) < TEXT_ROWS);
		// Text row 0 is the top page; pages count up from the bottom.
		glyph_base = AW'((PAGE_COUNT - 1 - int'(sel_row)) * SCREEN_COLUMNS +
		                 int'(sel_col) * pftc_pkg::GLYPH_WIDTH);
		glyph_x0   = 8'(int'(sel_col) * pftc_pkg::GLYPH_WIDTH);
		rd_in_range = (32'(read_addr) < STORE_BYTES);
	end

	always_comb begin
		col_inc = cursor_col_q + 5'd1;
		row_inc = {1'b0, cursor_row_q} + 4'd1;
		if (char_code == pftc_pkg::CHAR_NEWLINE) begin
			cur_col_next = 5'd0;
			cur_row_next = (row_inc >= 4'(TEXT_ROWS)) ? 3'd0 : row_inc[2:0];
		end else if (int'(col_inc) >= TEXT_COLUMNS) begin
			// Column wrap moves to the next row, and past the last row to home.
			cur_col_next = 5'd0;
			cur_row_next = (row_inc >= 4'(TEXT_ROWS)) ? 3'd0 : row_inc[2:0];
		end else begin
			cur_col_next = col_inc;
			cur_row_next = cursor_row_q;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			pftc_pkg::ST_CLEAR: begin
				if (addr_q == ADDR_LAST) state_next = pftc_pkg::ST_IDLE;
			end
			pftc_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						pftc_pkg::OP_FILL: state_next = pftc_pkg::ST_FILL;
						pftc_pkg::OP_SET_PIX, pftc_pkg::OP_CLR_PIX: begin
							state_next = pix_on_screen ? pftc_pkg::ST_READ : pftc_pkg::ST_FINISH;
						end
						pftc_pkg::OP_PUT_CUR: begin
							state_next = (char_code == pftc_pkg::CHAR_NEWLINE) ?
							             pftc_pkg::ST_FINISH : pftc_pkg::ST_GLYPH;
						end
						pftc_pkg::OP_PUT_CELL: begin
							state_next = cell_on_screen ? pftc_pkg::ST_GLYPH : pftc_pkg::ST_FINISH;
						end
						pftc_pkg::OP_READ: begin
							state_next = rd_in_range ? pftc_pkg::ST_READ : pftc_pkg::ST_FINISH;
						end
						default: state_next = pftc_pkg::ST_FINISH;
					endcase
				end
			end
			pftc_pkg::ST_FILL: begin
				if (addr_q == ADDR_LAST) state_next = pftc_pkg::ST_FINISH;
			end
			pftc_pkg::ST_READ: begin
				state_next = (op_q == pftc_pkg::OP_READ) ? pftc_pkg::ST_FINISH : pftc_pkg::ST_MODIFY;
			end
			pftc_pkg::ST_MODIFY: state_next = pftc_pkg::ST_FINISH;
			pftc_pkg::ST_GLYPH: begin
				if (step_q == pftc_pkg::GLYPH_LAST) state_next = pftc_pkg::ST_FINISH;
			end
			pftc_pkg::ST_FINISH: begin
				if (out_free) state_next = pftc_pkg::ST_IDLE;
			end
			default: state_next = pftc_pkg::ST_CLEAR;
		endcase
	end

	// Output and store-control logic.
	always_comb begin
		ctrl      = '0;
		mem_wdata = 8'h00;
		case (state_q)
			pftc_pkg::ST_CLEAR: begin
				ctrl.mem_we  = 1'b1;
				ctrl.advance = 1'b1;
			end
			pftc_pkg::ST_FILL: begin
				ctrl.mem_we  = 1'b1;
				ctrl.advance = 1'b1;
				mem_wdata    = fill_q;
			end
			pftc_pkg::ST_READ: ctrl.mem_re = 1'b1;
			pftc_pkg::ST_MODIFY: begin
				ctrl.mem_we = 1'b1;
				mem_wdata   = (op_q == pftc_pkg::OP_SET_PIX) ? (mem_rdata_q | bit_q) :
				                                               (mem_rdata_q & ~bit_q);
			end
			pftc_pkg::ST_GLYPH: begin
				// Columns past the right edge are skipped but still counted.
				ctrl.mem_we  = ({1'b0, glyph_x_q} < 9'(SCREEN_COLUMNS));
				ctrl.advance = 1'b1;
				mem_wdata    = pftc_pkg::glyph_byte(code_q, step_q);
			end
			pftc_pkg::ST_FINISH: ctrl.load_out = out_free;
			default: ctrl = '0;
		endcase
	end

	assign in_stall = (state_q != pftc_pkg::ST_IDLE);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pftc_pkg::ST_CLEAR;
			addr_q       <= '0;
			step_q       <= 3'd0;
			cursor_col_q <= 5'd0;
			cursor_row_q <= 3'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				step_q <= 3'd0;
				case (opcode)
					pftc_pkg::OP_FILL: addr_q <= '0;
					pftc_pkg::OP_SET_PIX, pftc_pkg::OP_CLR_PIX: addr_q <= pix_addr;
					pftc_pkg::OP_PUT_CUR, pftc_pkg::OP_PUT_CELL: addr_q <= glyph_base;
					pftc_pkg::OP_READ: addr_q <= read_addr[AW-1:0];
					default: addr_q <= addr_q;
				endcase
				if (opcode == pftc_pkg::OP_PUT_CUR) begin
					cursor_col_q <= cur_col_next;
					cursor_row_q <= cur_row_next;
				end
			end else if (ctrl.advance) begin
				addr_q <= addr_q + 1'b1;
				step_q <= step_q + 3'd1;
			end
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers; the word index is paddr bit 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_shift_q <= '0;
			y_shift_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				pftc_pkg::REG_X_ORIGIN: x_shift_q <= pwdata[7:0];
				pftc_pkg::REG_Y_ORIGIN: y_shift_q <= pwdata[6:0];
				default: x_shift_q <= x_shift_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pftc_pkg::REG_X_ORIGIN: prdata = {24'h0, x_shift_q};
			pftc_pkg::REG_Y_ORIGIN: prdata = {25'h0, y_shift_q};
			default: prdata = 32'h0;
		endcase
	end

	assign pready = 1'b1;

	// Operand and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			fill_q    <= fill_value;
			code_q    <= char_code;
			bit_q     <= 8'h01 << y_sum[2:0];
			glyph_x_q <= glyph_x0;
			rd_sel_q  <= (opcode == pftc_pkg::OP_READ) && rd_in_range;
			status_q  <= (((opcode == pftc_pkg::OP_SET_PIX) || (opcode == pftc_pkg::OP_CLR_PIX)) &&
			              !pix_on_screen) ||
			             ((opcode == pftc_pkg::OP_PUT_CELL) && !cell_on_screen);
		end else if (ctrl.advance) begin
			glyph_x_q <= glyph_x_q + 8'd1;
		end
		if (ctrl.load_out) begin
			read_data_q      <= rd_sel_q ? mem_rdata_q : 8'h00;
			status_out_q     <= status_q;
			cursor_col_out_q <= cursor_col_q;
			cursor_row_out_q <= cursor_row_q;
		end
	end

	// Frame store: one address, one write or one read a cycle.
	always_ff @(posedge clk) begin
		if (ctrl.mem_we) frame_store_q[addr_q] <= mem_wdata;
		if (ctrl.mem_re) mem_rdata_q <= frame_store_q[addr_q];
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign status         = status_out_q;
	assign cursor_col_now = cursor_col_out_q;
	assign cursor_row_now = cursor_row_out_q;

endmodule

`default_nettype wire

### rtl/pftc_checker.sv
// ----------------------------------------------------------------------------
// pftc_checker: port-level checks for the page frame buffer text console
// Watches the word channels and flags slips in sequencing and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pftc_checker #(
	parameter int TEXT_COLUMNS = 21
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_data,
	input wire logic       status,
	input wire logic [4:0] cursor_col_now
);

	// A finished word waits while the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// An accepted word leaves the sequencer busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after acceptance");

	// Only a read returns data, and a rejected pixel or cell is never a read.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_data == 8'h00)
		else $error("read data present on an off-screen status");

	// The reported cursor column stays inside the text grid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_col_now) < TEXT_COLUMNS)
		else $error("cursor column past the text grid");

endmodule

bind page_framebuffer_text_console pftc_checker #(
	.TEXT_COLUMNS(TEXT_COLUMNS)
) u_pftc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.read_data     (read_data),
	.status        (status),
	.cursor_col_now(cursor_col_now)
);

`default_nettype wire
